// ----- rtl/core/tmh_pkg.sv -----
// ============================================================================
// Triangle metrics package
// Shared widths and default parameter values for the Heron triangle block.
// ============================================================================
package tmh_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int PERIM_W  = 27;
    localparam int AREA_W   = 40;
    localparam int HEIGHT_W = 25;

endpackage

// ----- rtl/core/tmh_if.sv -----
// ============================================================================
// Triangle metrics channels
// Valid/ready channels for point triples in and triangle metrics out.
// ============================================================================
interface tmh_in_if #(
    parameter int COORD_BITS = tmh_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;

    modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface tmh_out_if;
    logic                         valid;
    logic                         ready;
    logic [tmh_pkg::PERIM_W-1:0]  perim;
    logic [tmh_pkg::AREA_W-1:0]   tri_area;
    logic [tmh_pkg::HEIGHT_W-1:0] height_ab;
    logic [tmh_pkg::HEIGHT_W-1:0] height_ac;
    logic [tmh_pkg::HEIGHT_W-1:0] height_bc;
    logic                         degenerate;

    modport source (output valid, perim, tri_area, height_ab, height_ac, height_bc,
                    degenerate, input ready);
    modport sink   (input valid, perim, tri_area, height_ab, height_ac, height_bc,
                    degenerate, output ready);
endinterface

// ----- rtl/core/tmh_isqrt.sv -----
// ============================================================================
// Pipelined integer square root
// One result bit per stage, several lanes sharing one valid and one tag.
// ============================================================================
module tmh_isqrt #(
    parameter int LANES = 1,
    parameter int IN_W  = 4,
    parameter int OUT_W = (IN_W + 1) / 2,
    parameter int TAG_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [LANES-1:0][IN_W-1:0]   rad,
    input  logic [TAG_W-1:0]             in_tag,
    output logic                         out_valid,
    output logic [LANES-1:0][OUT_W-1:0]  root,
    output logic [TAG_W-1:0]             out_tag
);
    localparam int PAD_W = 2 * OUT_W;
    localparam int REM_W = OUT_W + 2;

    logic [OUT_W-1:0]                valid_reg;
    logic [LANES-1:0][PAD_W-1:0]     rad_reg  [OUT_W];
    logic [LANES-1:0][REM_W-1:0]     rem_reg  [OUT_W];
    logic [LANES-1:0][OUT_W-1:0]     root_reg [OUT_W];
    logic [TAG_W-1:0]                tag_reg  [OUT_W];

    genvar s;
    generate
        for (s = 0; s < OUT_W; s++)
        begin : g_stage
            logic                        prev_valid;
            logic [LANES-1:0][PAD_W-1:0] prev_rad;
            logic [LANES-1:0][REM_W-1:0] prev_rem;
            logic [LANES-1:0][OUT_W-1:0] prev_root;
            logic [TAG_W-1:0]            prev_tag;
            logic [LANES-1:0][PAD_W-1:0] rad_next;
            logic [LANES-1:0][REM_W-1:0] rem_next;
            logic [LANES-1:0][OUT_W-1:0] root_next;

            if (s == 0)
            begin : g_first
                always_comb
                begin
                    prev_valid = in_valid;
                    prev_tag   = in_tag;
                    prev_rem   = '0;
                    prev_root  = '0;
                    for (int l = 0; l < LANES; l++)
                    begin
                        prev_rad[l] = PAD_W'(rad[l]);
                    end
                end
            end
            else
            begin : g_later
                assign prev_valid = valid_reg[s-1];
                assign prev_rad   = rad_reg[s-1];
                assign prev_rem   = rem_reg[s-1];
                assign prev_root  = root_reg[s-1];
                assign prev_tag   = tag_reg[s-1];
            end

            always_comb
            begin : step
                logic [REM_W-1:0] rem_t;
                logic [REM_W-1:0] trial;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_t = {prev_rem[l][OUT_W-1:0], prev_rad[l][PAD_W-1 -: 2]};
                    trial = {prev_root[l], 2'b01};
                    if (rem_t >= trial)
                    begin
                        rem_next[l]  = rem_t - trial;
                        root_next[l] = {prev_root[l][OUT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l]  = rem_t;
                        root_next[l] = {prev_root[l][OUT_W-2:0], 1'b0};
                    end
                    rad_next[l] = prev_rad[l] << 2;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[s]  <= rad_next;
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                    tag_reg[s]  <= prev_tag;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign out_tag   = tag_reg[OUT_W-1];

endmodule

// ----- rtl/core/tmh_div.sv -----
// ============================================================================
// Pipelined saturating divider
// Restoring division, one quotient bit per stage, shared dividend, per-lane
// divisors; a zero divisor gives zero, an oversized quotient saturates.
// ============================================================================
module tmh_div #(
    parameter int LANES = 1,
    parameter int NUM_W = 8,
    parameter int DEN_W = 4,
    parameter int Q_W   = 4,
    parameter int TAG_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [NUM_W-1:0]            num,
    input  logic [LANES-1:0][DEN_W-1:0] den,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [LANES-1:0][Q_W-1:0]   quo,
    output logic [TAG_W-1:0]            out_tag
);
    logic [Q_W:0]                  valid_reg;
    logic [LANES-1:0][DEN_W-1:0]   rem_reg  [Q_W+1];
    logic [LANES-1:0][DEN_W-1:0]   den_reg  [Q_W+1];
    logic [LANES-1:0][Q_W-1:0]     q_reg    [Q_W+1];
    logic [Q_W-1:0]                low_reg  [Q_W+1];
    logic [LANES-1:0]              sat_reg  [Q_W+1];
    logic [LANES-1:0]              zero_reg [Q_W+1];
    logic [TAG_W-1:0]              tag_reg  [Q_W+1];

    logic [LANES-1:0][DEN_W-1:0]   rem0_next;
    logic [LANES-1:0]              sat0_next;
    logic [LANES-1:0]              zero0_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            sat0_next[l]  = (num >> Q_W) >= NUM_W'(den[l]);
            rem0_next[l]  = DEN_W'(num >> Q_W);
            zero0_next[l] = (den[l] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem0_next;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            low_reg[0]  <= num[Q_W-1:0];
            sat_reg[0]  <= sat0_next;
            zero_reg[0] <= zero0_next;
            tag_reg[0]  <= in_tag;
        end
    end

    genvar s;
    generate
        for (s = 1; s <= Q_W; s++)
        begin : g_stage
            logic [LANES-1:0][DEN_W-1:0] rem_next;
            logic [LANES-1:0][Q_W-1:0]   q_next;

            always_comb
            begin : step
                logic [DEN_W:0] rem_t;
                logic [DEN_W:0] den_x;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_t = {rem_reg[s-1][l], low_reg[s-1][Q_W-1]};
                    den_x = {1'b0, den_reg[s-1][l]};
                    if (rem_t >= den_x)
                    begin
                        rem_next[l] = DEN_W'(rem_t - den_x);
                        q_next[l]   = {q_reg[s-1][l][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[l] = DEN_W'(rem_t);
                        q_next[l]   = {q_reg[s-1][l][Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next;
                    den_reg[s]  <= den_reg[s-1];
                    q_reg[s]    <= q_next;
                    low_reg[s]  <= low_reg[s-1] << 1;
                    sat_reg[s]  <= sat_reg[s-1];
                    zero_reg[s] <= zero_reg[s-1];
                    tag_reg[s]  <= tag_reg[s-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (zero_reg[Q_W][l])
            begin
                quo[l] = '0;
            end
            else if (sat_reg[Q_W][l])
            begin
                quo[l] = '1;
            end
            else
            begin
                quo[l] = q_reg[Q_W][l];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign out_tag   = tag_reg[Q_W];

endmodule

// ----- rtl/core/triangle_metrics_heron.sv -----
// ============================================================================
// Triangle metrics by Heron's formula
// Perimeter, area and the three heights of a triangle given by three points.
// ============================================================================
// Usage: din carries one point triple per transaction (signed coordinates,
// FRAC_BITS fraction bits); dout carries one result transaction per input:
// perimeter, area, three heights and a flag for a zero-length side.
// Both channels complete a transaction when valid and ready are high at a
// rising clock edge.
// Throughput is one transaction per cycle while dout is not stalled. Results
// pass through three stages of differences and squares, the side square
// roots (COORD_BITS+2 stages), four stages of sides and products, the area
// square root (40 stages), the height dividers (26 stages) and the output
// register. The area root and the dividers resolve one bit per stage.
// The whole pipeline advances together; when dout is stalled with a result
// waiting, din.ready drops and every stage holds its contents.
// Reset clears all valid bits; nothing else needs initialization.
// ============================================================================
module triangle_metrics_heron #(
    parameter int COORD_BITS = tmh_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tmh_pkg::FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tmh_in_if.sink    din,
    tmh_out_if.source dout
);
    import tmh_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SIDE_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int RAD_W  = SQ_W + 1;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int P_W    = SIDE_W + 2;
    localparam int T_W    = SIDE_W + 1;
    localparam int M1_W   = P_W + T_W;
    localparam int M2_W   = 2 * T_W;
    localparam int H_W    = (M1_W + 1) / 2;
    localparam int R_W    = M1_W + M2_W;
    localparam int SHIFT  = 2 * FRAC_BITS + 4;
    localparam int EXT_W  = R_W + 2 * AREA_W;
    localparam int NUM_W  = AREA_W + FRAC_BITS + 1;

    typedef struct packed {
        logic [P_W-1:0]              p;
        logic [2:0][SIDE_W-1:0]      side;
        logic [2:0]                  zero;
        logic                        ok;
    } carry_t;

    typedef struct packed {
        logic                        sat;
        logic [PERIM_W-1:0]          perim;
        logic [2:0][SIDE_W-1:0]      side;
        logic [2:0]                  zero;
    } area_tag_t;

    typedef struct packed {
        logic [PERIM_W-1:0]          perim;
        logic [AREA_W-1:0]           area;
        logic [2:0]                  zero;
    } div_tag_t;

    logic adv;
    logic out_valid_reg;

    assign adv       = !out_valid_reg || dout.ready;
    assign din.ready = adv;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] p,
                                                   input logic signed [COORD_BITS-1:0] q);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(p) - DIFF_W'(q);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    // Coordinate differences: ab, ac and bc, x then y.
    logic                 s1_valid_reg;
    logic [DIFF_W-1:0]    d_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= abs_diff(din.bx, din.ax);
            d_reg[1] <= abs_diff(din.by_coord, din.ay);
            d_reg[2] <= abs_diff(din.cx, din.ax);
            d_reg[3] <= abs_diff(din.cy, din.ay);
            d_reg[4] <= abs_diff(din.cx, din.bx);
            d_reg[5] <= abs_diff(din.cy, din.by_coord);
        end
    end

    logic                 s2_valid_reg;
    logic [SQ_W-1:0]      sq_reg [6];
    logic [2:0]           s2_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
            begin
                sq_reg[i] <= SQ_W'(d_reg[i]) * SQ_W'(d_reg[i]);
            end
            for (int k = 0; k < 3; k++)
            begin
                s2_zero_reg[k] <= (d_reg[2*k] == '0) && (d_reg[2*k+1] == '0);
            end
        end
    end

    logic                     s3_valid_reg;
    logic [2:0][RAD_W-1:0]    s3_rad_reg;
    logic [2:0]               s3_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_rad_reg[k] <= RAD_W'(sq_reg[2*k]) + RAD_W'(sq_reg[2*k+1]);
            end
            s3_zero_reg <= s2_zero_reg;
        end
    end

    logic                     side_valid;
    logic [2:0][ROOT_W-1:0]   side_root;
    logic [2:0]               side_zero;

    tmh_isqrt #(
        .LANES (3),
        .IN_W  (RAD_W),
        .OUT_W (ROOT_W),
        .TAG_W (3)
    ) u_side_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .rad       (s3_rad_reg),
        .in_tag    (s3_zero_reg),
        .out_valid (side_valid),
        .root      (side_root),
        .out_tag   (side_zero)
    );

    // Sides, perimeter and the three Heron terms.
    carry_t               s4_next;
    logic [2:0][T_W-1:0]  t_next;
    logic [SIDE_W-1:0]    sa;
    logic [SIDE_W-1:0]    sb;
    logic [SIDE_W-1:0]    sc;

    always_comb
    begin
        sa = SIDE_W'(side_root[0]);
        sb = SIDE_W'(side_root[1]);
        sc = SIDE_W'(side_root[2]);
        s4_next.p    = P_W'(sa) + P_W'(sb) + P_W'(sc);
        s4_next.side = {sc, sb, sa};
        s4_next.zero = side_zero;
        s4_next.ok   = (T_W'(sa) <= T_W'(sb) + T_W'(sc)) &&
                       (T_W'(sb) <= T_W'(sa) + T_W'(sc)) &&
                       (T_W'(sc) <= T_W'(sa) + T_W'(sb));
        if (s4_next.ok)
        begin
            t_next[0] = T_W'(sb) + T_W'(sc) - T_W'(sa);
            t_next[1] = T_W'(sa) + T_W'(sc) - T_W'(sb);
            t_next[2] = T_W'(sa) + T_W'(sb) - T_W'(sc);
        end
        else
        begin
            t_next = '0;
        end
    end

    logic                 s4_valid_reg;
    carry_t               s4_carry_reg;
    logic [2:0][T_W-1:0]  s4_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= side_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_carry_reg <= s4_next;
            s4_t_reg     <= t_next;
        end
    end

    logic                 s5_valid_reg;
    carry_t               s5_carry_reg;
    logic [M1_W-1:0]      m1_reg;
    logic [M2_W-1:0]      m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_carry_reg <= s4_carry_reg;
            m1_reg <= M1_W'(s4_carry_reg.p) * M1_W'(s4_t_reg[0]);
            m2_reg <= M2_W'(s4_t_reg[1]) * M2_W'(s4_t_reg[2]);
        end
    end

    // The wide product is formed from four partial products.
    logic                      s6_valid_reg;
    carry_t                    s6_carry_reg;
    logic [2*H_W-1:0]          pp_ll_reg;
    logic [2*H_W-1:0]          pp_lh_reg;
    logic [2*H_W-1:0]          pp_hl_reg;
    logic [2*H_W-1:0]          pp_hh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_carry_reg <= s5_carry_reg;
            pp_ll_reg <= (2*H_W)'(m1_reg[H_W-1:0]) * (2*H_W)'(m2_reg[H_W-1:0]);
            pp_lh_reg <= (2*H_W)'(m1_reg[H_W-1:0]) * (2*H_W)'(m2_reg[M2_W-1:H_W]);
            pp_hl_reg <= (2*H_W)'(m1_reg[M1_W-1:H_W]) * (2*H_W)'(m2_reg[H_W-1:0]);
            pp_hh_reg <= (2*H_W)'(m1_reg[M1_W-1:H_W]) * (2*H_W)'(m2_reg[M2_W-1:H_W]);
        end
    end

    logic [R_W-1:0]       prod;
    logic [EXT_W-1:0]     quart;
    area_tag_t            atag_next;

    always_comb
    begin
        prod  = (R_W'(pp_hh_reg) << (2 * H_W)) +
                ((R_W'(pp_lh_reg) + R_W'(pp_hl_reg)) << H_W) +
                R_W'(pp_ll_reg);
        quart = EXT_W'(prod) >> SHIFT;
        atag_next.sat   = s6_carry_reg.ok && (|quart[EXT_W-1:2*AREA_W]);
        atag_next.perim = PERIM_W'(s6_carry_reg.p);
        atag_next.side  = s6_carry_reg.side;
        atag_next.zero  = s6_carry_reg.zero;
    end

    logic                     s7_valid_reg;
    area_tag_t                s7_tag_reg;
    logic [2*AREA_W-1:0]      s7_rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_tag_reg <= atag_next;
            s7_rad_reg <= s6_carry_reg.ok ? quart[2*AREA_W-1:0] : '0;
        end
    end

    logic                 area_valid;
    logic [AREA_W-1:0]    area_root;
    area_tag_t            area_tag;

    tmh_isqrt #(
        .LANES (1),
        .IN_W  (2 * AREA_W),
        .OUT_W (AREA_W),
        .TAG_W ($bits(area_tag_t))
    ) u_area_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s7_valid_reg),
        .rad       (s7_rad_reg),
        .in_tag    (s7_tag_reg),
        .out_valid (area_valid),
        .root      (area_root),
        .out_tag   (area_tag)
    );

    logic [AREA_W-1:0]    area;
    logic [NUM_W-1:0]     dividend;
    div_tag_t             dtag_next;

    always_comb
    begin
        area            = area_tag.sat ? '1 : area_root;
        dividend        = NUM_W'(area) << (FRAC_BITS + 1);
        dtag_next.perim = area_tag.perim;
        dtag_next.area  = area;
        dtag_next.zero  = area_tag.zero;
    end

    logic                       div_valid;
    logic [2:0][HEIGHT_W-1:0]   height;
    div_tag_t                   div_tag;

    tmh_div #(
        .LANES (3),
        .NUM_W (NUM_W),
        .DEN_W (SIDE_W),
        .Q_W   (HEIGHT_W),
        .TAG_W ($bits(div_tag_t))
    ) u_height_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (area_valid),
        .num       (dividend),
        .den       (area_tag.side),
        .in_tag    (dtag_next),
        .out_valid (div_valid),
        .quo       (height),
        .out_tag   (div_tag)
    );

    logic [PERIM_W-1:0]   perim_reg;
    logic [AREA_W-1:0]    area_reg;
    logic [HEIGHT_W-1:0]  hab_reg;
    logic [HEIGHT_W-1:0]  hac_reg;
    logic [HEIGHT_W-1:0]  hbc_reg;
    logic                 degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            perim_reg <= div_tag.perim;
            area_reg  <= div_tag.area;
            hab_reg   <= height[0];
            hac_reg   <= height[1];
            hbc_reg   <= height[2];
            degen_reg <= |div_tag.zero;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.perim      = perim_reg;
    assign dout.tri_area   = area_reg;
    assign dout.height_ab  = hab_reg;
    assign dout.height_ac  = hac_reg;
    assign dout.height_bc  = hbc_reg;
    assign dout.degenerate = degen_reg;

`ifndef SYNTHESIS
    ap_area_not_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && (dout.tri_area != '0) |-> !dout.degenerate)
        else $error("Nonzero area reported for a triangle with a zero-length side.");

    ap_zero_area_heights: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && (dout.tri_area == '0) |->
            (dout.height_ab == '0) && (dout.height_ac == '0) && (dout.height_bc == '0))
        else $error("Nonzero height reported with zero area.");

    ap_degenerate_height: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && dout.degenerate |->
            (dout.height_ab == '0) || (dout.height_ac == '0) || (dout.height_bc == '0))
        else $error("Degenerate transaction without a zeroed height.");
`endif

endmodule

// ----- sim/tmh_checker.sv -----
// ============================================================================
// Triangle metrics checker
// Watches both channels of the Heron triangle block. It predicts every result
// from the accepted point triple and compares each result field by field.
// ============================================================================
module tmh_checker (
    input  logic clk,
    input  logic rst_n,
    tmh_in_if    din,
    tmh_out_if   dout,
    output int   errors,
    output int   outstanding
);
    import tmh_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    typedef struct packed {
        logic [PERIM_W-1:0]  perim;
        logic [AREA_W-1:0]   tri_area;
        logic [HEIGHT_W-1:0] height_ab;
        logic [HEIGHT_W-1:0] height_ac;
        logic [HEIGHT_W-1:0] height_bc;
        logic                degenerate;
    } metrics_t;

    metrics_t pending_metrics[$];

    function automatic logic [63:0] isqrt128(logic [127:0] q);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (64'd1 << i);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= q)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] side_length(longint x1, longint y1, longint x2,
                                                longint y2);
        longint       dx;
        longint       dy;
        logic [127:0] sum;
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        sum = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy};
        return isqrt128(sum);
    endfunction

    function automatic logic [HEIGHT_W-1:0] height_for(logic [63:0] area,
                                                       logic [63:0] side);
        logic [63:0] h;
        if (side == 0)
            return '0;
        h = ((area * 2) << FRAC) / side;
        if (h > {HEIGHT_W{1'b1}})
            return {HEIGHT_W{1'b1}};
        return h[HEIGHT_W-1:0];
    endfunction

    function automatic metrics_t triangle_metrics(longint ax, longint ay, longint bx,
                                                  longint by, longint cx, longint cy);
        metrics_t     m;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  c;
        logic [63:0]  p;
        logic [63:0]  area;
        logic [127:0] r;
        a = side_length(ax, ay, bx, by);
        b = side_length(ax, ay, cx, cy);
        c = side_length(bx, by, cx, cy);
        p = a + b + c;
        area = '0;
        if (a <= b + c && b <= a + c && c <= a + b)
        begin
            r = {64'd0, p * (b + c - a)} * {64'd0, (a + c - b) * (a + b - c)};
            area = isqrt128(r >> (2 * FRAC + 4));
            if (area > {AREA_W{1'b1}})
                area = {AREA_W{1'b1}};
        end
        m.perim      = p[PERIM_W-1:0];
        m.tri_area   = area[AREA_W-1:0];
        m.height_ab  = height_for(area, a);
        m.height_ac  = height_for(area, b);
        m.height_bc  = height_for(area, c);
        m.degenerate = (a == 0 || b == 0 || c == 0);
        return m;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        metrics_t want;
        if (!rst_n)
        begin
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (dout.valid && dout.ready)
            begin
                if (pending_metrics.size() == 0)
                begin
                    $error("result transaction with no expected result");
                    errors <= errors + 1;
                end
                else
                begin
                    want = pending_metrics.pop_front();
                    if (dout.perim !== want.perim ||
                        dout.tri_area !== want.tri_area ||
                        dout.height_ab !== want.height_ab ||
                        dout.height_ac !== want.height_ac ||
                        dout.height_bc !== want.height_bc ||
                        dout.degenerate !== want.degenerate)
                        errors <= errors + 1;
                    if (dout.perim !== want.perim)
                        $error("perim expected %0d actual %0d", want.perim, dout.perim);
                    if (dout.tri_area !== want.tri_area)
                        $error("tri_area expected %0d actual %0d", want.tri_area,
                               dout.tri_area);
                    if (dout.height_ab !== want.height_ab)
                        $error("height_ab expected %0d actual %0d", want.height_ab,
                               dout.height_ab);
                    if (dout.height_ac !== want.height_ac)
                        $error("height_ac expected %0d actual %0d", want.height_ac,
                               dout.height_ac);
                    if (dout.height_bc !== want.height_bc)
                        $error("height_bc expected %0d actual %0d", want.height_bc,
                               dout.height_bc);
                    if (dout.degenerate !== want.degenerate)
                        $error("degenerate expected %0d actual %0d", want.degenerate,
                               dout.degenerate);
                end
            end
            if (din.valid && din.ready)
                pending_metrics.push_back(triangle_metrics(din.ax, din.ay, din.bx,
                                                           din.by_coord, din.cx, din.cy));
            outstanding <= pending_metrics.size();
        end
    end
endmodule

// ----- sim/tb_triangle_metrics_heron.sv -----
// ============================================================================
// Triangle metrics testbench
// Drives directed and random point triples into the Heron triangle block with
// random gaps and output stalls, including one long stall that fills the
// pipeline, and reports the verdict from the checker's failure count.
// ============================================================================
module tb_triangle_metrics_heron;
    import tmh_pkg::*;

    localparam int CW        = COORD_BITS_DEF;
    localparam int N_RANDOM  = 1700;
    localparam int LATENCY   = COORD_BITS_DEF + 76;
    localparam int MAX_CYCLE = 2000000;

    typedef logic signed [CW-1:0] coord_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   cycles;
    int   accepted;

    tmh_in_if #(.COORD_BITS(CW)) din ();
    tmh_out_if                   dout ();

    triangle_metrics_heron uut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    tmh_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .din         (din),
        .dout        (dout),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic coord_t any_coord();
        logic [31:0] r;
        r = $urandom();
        return r[CW-1:0];
    endfunction

    function automatic coord_t near_coord();
        return coord_t'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    task automatic send_triple(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                               coord_t cx, coord_t cy);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            din.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        din.valid    = 1'b1;
        din.ax       = ax;
        din.ay       = ay;
        din.bx       = bx;
        din.by_coord = by;
        din.cx       = cx;
        din.cy       = cy;
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
        accepted++;
        @(negedge clk);
    endtask

    task automatic random_triple();
        coord_t p[6];
        int     kind;
        int     k;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++)
            p[i] = (kind < 5) ? near_coord() : any_coord();
        if (kind == 7)
        begin
            p[4] = p[0];
            p[5] = p[1];
        end
        else if (kind == 8)
        begin
            k = int'($urandom_range(0, 6)) - 3;
            p[2] = p[0] + near_coord() / 4;
            p[3] = p[1] + near_coord() / 4;
            p[4] = p[0] + (p[2] - p[0]) * coord_t'(k);
            p[5] = p[1] + (p[3] - p[1]) * coord_t'(k);
        end
        send_triple(p[0], p[1], p[2], p[3], p[4], p[5]);
    endtask

    initial
    begin
        int stall;
        bit long_done;
        dout.ready = 1'b0;
        long_done  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_done && accepted >= 300)
            begin
                dout.ready = 1'b0;
                stall = 0;
                while (stall < 400)
                begin
                    @(negedge clk);
                    stall++;
                end
                dout.ready = 1'b1;
                long_done  = 1'b1;
            end
            else if ($urandom_range(0, 99) < 25)
            begin
                dout.ready = 1'b0;
                repeat (gap_length()) @(negedge clk);
            end
            else
            begin
                dout.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        coord_t mx;
        coord_t mn;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cycles       = 0;
        accepted     = 0;
        din.valid    = 1'b0;
        din.ax       = '0;
        din.ay       = '0;
        din.bx       = '0;
        din.by_coord = '0;
        din.cx       = '0;
        din.cy       = '0;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_triple('0, '0, '0, '0, '0, '0);
        send_triple('0, '0, coord_t'(3 << 8), '0, '0, coord_t'(4 << 8));
        send_triple(coord_t'(256), coord_t'(256), coord_t'(256), coord_t'(256),
                    coord_t'(1024), '0);
        send_triple('0, '0, coord_t'(256), coord_t'(256), coord_t'(512), coord_t'(512));
        send_triple('0, '0, coord_t'(1), '0, coord_t'(2), '0);
        send_triple('0, '0, coord_t'(1), '0, '0, coord_t'(1));
        send_triple(mn, mn, mx, mn, mn, mx);
        send_triple(mx, mx, mn, mn, mx, mn);
        send_triple(mn, mx, mx, mn, mn, mn);
        send_triple(mx, mx, mx, mx, mx, mx);
        send_triple(mn, mn, mn, mn, mn, mn);
        send_triple(mn, '0, mx, '0, '0, mx);
        send_triple(mn, mn, mx, mx, coord_t'(1), '0);
        send_triple(coord_t'(-1), coord_t'(-1), coord_t'(1), coord_t'(1),
                    coord_t'(-1), coord_t'(1));
        send_triple('0, '0, coord_t'(1000), coord_t'(1), coord_t'(2000), coord_t'(3));
        send_triple(coord_t'(-5000), coord_t'(300), coord_t'(7000), coord_t'(-100),
                    coord_t'(12), coord_t'(9000));

        for (int i = 0; i < N_RANDOM; i++)
            random_triple();
        din.valid = 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
